// ----- rtl/core/npcs_pkg.sv -----
// Shared types and constants for the nearest palette color search block.
// No dependencies; imported by the controller, the datapath and the top level.
package npcs_pkg;

   // Default palette depth and widest palette address.
   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int ADDR_W_MAX              = 8;
   localparam int DIST_W                  = 18;

   // Item codes carried on the cmd field.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic                  wr_en;
      logic                  start;
      logic                  rd_en;
      logic [ADDR_W_MAX-1:0] rd_addr;
      logic                  load_out;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic pipe_empty;
      logic out_free;
   } dp_status_type;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

endpackage

// ----- rtl/core/npcs_ctrl.sv -----
// Controller state machine: accepts transactions and sequences the palette scan.
// Depends on npcs_pkg.
module npcs_ctrl #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   input  logic [7:0]             req_entry_index,
   input  npcs_pkg::dp_status_type status,
   output logic                   req_stall,
   output npcs_pkg::ctrl_cmd_type  cmd
);
   import npcs_pkg::*;

   localparam int         AW        = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] IDX_LIMIT = 9'(PALETTE_ENTRIES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic           in_range;

   assign in_range = ({1'b0, req_entry_index} < IDX_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_cmd == CMD_QUERY) begin
                  cmd.start = 1'b1;
                  addr_in   = '0;
                  state_in  = ST_SCAN;
               end else begin
                  // drop writes beyond the palette
                  cmd.wr_en = in_range;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ADDR_W_MAX'(addr_ff);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/npcs_datapath.sv -----
// Datapath: palette memory, distance pipeline, running minimum and result register.
// Depends on npcs_pkg.
module npcs_datapath #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  npcs_pkg::ctrl_cmd_type        cmd,
   input  logic [7:0]                   req_entry_index,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_best_index,
   output logic [npcs_pkg::DIST_W-1:0]  rsp_best_distance,
   output logic                         rsp_exact_match,
   output npcs_pkg::dp_status_type       status
);
   import npcs_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);

   logic [23:0] mem [PALETTE_ENTRIES];

   // Query pixel
   logic [7:0] pix_r_ff, pix_g_ff, pix_b_ff;

   // Stage 1: registered memory read
   logic          s1_valid_ff;
   logic [AW-1:0] s1_idx_ff;
   logic [23:0]   s1_data_ff;

   // Stage 2: registered squares
   logic          s2_valid_ff;
   logic [AW-1:0] s2_idx_ff;
   logic [15:0]   s2_sq_r_ff, s2_sq_g_ff, s2_sq_b_ff;
   logic [7:0]    diff_r, diff_g, diff_b;

   // Running best
   logic [AW-1:0]     best_idx_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [DIST_W-1:0] dist_sum;
   logic              take;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_idx_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_exact_ff;

   assign diff_r = abs_diff(s1_data_ff[23:16], pix_r_ff);
   assign diff_g = abs_diff(s1_data_ff[15:8], pix_g_ff);
   assign diff_b = abs_diff(s1_data_ff[7:0], pix_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[req_entry_index[AW-1:0]] <= {req_red, req_green, req_blue};
      end
      if (cmd.rd_en) begin
         s1_data_ff <= mem[cmd.rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pix_r_ff <= req_red;
         pix_g_ff <= req_green;
         pix_b_ff <= req_blue;
      end
      s1_idx_ff  <= cmd.rd_addr[AW-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_sq_r_ff <= 16'(diff_r) * 16'(diff_r);
      s2_sq_g_ff <= 16'(diff_g) * 16'(diff_g);
      s2_sq_b_ff <= 16'(diff_b) * 16'(diff_b);
      if (take) begin
         best_idx_ff  <= s2_idx_ff;
         best_dist_ff <= dist_sum;
      end
      if (cmd.load_out) begin
         rsp_idx_ff   <= 8'(best_idx_ff);
         rsp_dist_ff  <= best_dist_ff;
         rsp_exact_ff <= (best_dist_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign dist_sum = DIST_W'(s2_sq_r_ff) + DIST_W'(s2_sq_g_ff) + DIST_W'(s2_sq_b_ff);
   // first entry seeds the minimum; later entries replace it only when strictly closer
   assign take = s2_valid_ff && ((s2_idx_ff == '0) || (dist_sum < best_dist_ff));

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_idx_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_exact_match   = rsp_exact_ff;

endmodule

// ----- rtl/core/nearest_palette_color_search_top.sv -----
// Top level of the nearest palette color search block.
// Depends on npcs_pkg, npcs_ctrl and npcs_datapath.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  cmd, entry_index, red, green, blue
//   rsp_     out        rsp_valid/rsp_stall  best_index, best_distance, exact_match
//
// A write transaction goes straight into the palette memory. A query scans the palette
// memory, which delivers one entry per cycle, through the read, square and compare
// stages, waits for them to drain and loads its result once the result register is free;
// the next transaction is accepted in the cycle after the load. Reset is synchronous and
// active high; the palette is not cleared and must be written before it is queried. A stalled
// result sits in its own register while new writes and the next query go ahead.
module nearest_palette_color_search_top #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [7:0]                   req_entry_index,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_best_index,
   output logic [npcs_pkg::DIST_W-1:0]  rsp_best_distance,
   output logic                         rsp_exact_match
);
   import npcs_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Sequence transactions: writes go straight to memory, queries start a scan.
   npcs_ctrl #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .status          (dp_status),
      .req_stall       (req_stall),
      .cmd             (ctrl_cmd)
   );

   // Hold the palette, compute distances and track the closest entry.
   npcs_datapath #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctrl_cmd),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance),
      .rsp_exact_match   (rsp_exact_match),
      .status            (dp_status)
   );

`ifndef SYNTHESIS
   // A new result never overwrites one still waiting to be taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_out |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // A result appears only after the controller loads it.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl_cmd.load_out))
      else $error("result valid without load");

   // Input side is closed while the palette is being scanned.
   a_stall_in_scan: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.rd_en |-> req_stall)
      else $error("input open during scan");

   // Exact-match flag agrees with the distance.
   a_exact_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_exact_match == (rsp_best_distance == '0)))
      else $error("exact match flag mismatch");
`endif

endmodule
